// ----- sv/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

  localparam int DATA_WIDTH = 31;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic  dbz;
    data_t rem;
    data_t acc;
    data_t div;
  } stage_t;

endpackage
`default_nettype wire

// ----- sv/ssd_in_if.sv -----
`default_nettype none
interface ssd_in_if
  import ssd_pkg::*;
;
  logic  valid;
  logic  ready;
  data_t dividend;
  data_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

// ----- sv/ssd_out_if.sv -----
`default_nettype none
interface ssd_out_if
  import ssd_pkg::*;
;
  logic  valid;
  logic  ready;
  data_t quotient;
  logic  divide_by_zero;

  modport source (output valid, output quotient, output divide_by_zero, input ready);
  modport sink (input valid, input quotient, input divide_by_zero, output ready);
endinterface
`default_nettype wire

// ----- sv/ssd_stage.sv -----
`default_nettype none
module ssd_stage
  import ssd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire stage_t in_data,
  output logic        out_valid,
  output stage_t      out_data
);

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH+1:0] diff;
  logic                  fits;
  stage_t                data_next;

  // one restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial          = {in_data.rem, in_data.acc[DATA_WIDTH-1]};
    diff           = {1'b0, trial} - {2'b00, in_data.div};
    fits           = ~diff[DATA_WIDTH+1];
    data_next.dbz  = in_data.dbz;
    data_next.div  = in_data.div;
    data_next.rem  = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    data_next.acc  = {in_data.acc[DATA_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/shift_subtract_divider.sv -----
// Pipeline: one registered stage per quotient bit between accepted item and result.
// Throughput: one item per cycle when not stalled; each stage holds one compare/subtract of DATA_WIDTH+1 bits.
// Stall: when a result waits untaken, the whole stage chain holds and operands.ready drops.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
`default_nettype none
module shift_subtract_divider
  import ssd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  ssd_in_if.sink    operands,
  ssd_out_if.source result
);

  logic                  adv;
  logic [DATA_WIDTH-1:0] vld;
  stage_t                data [DATA_WIDTH];
  stage_t                head;

  assign adv            = ~result.valid | result.ready;
  assign operands.ready = adv;

  always_comb begin
    head.dbz = (operands.divisor == '0);
    head.rem = '0;
    head.acc = operands.dividend;
    head.div = operands.divisor;
  end

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
    if (i == 0) begin : g_first
      ssd_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .in_valid  (operands.valid),
        .in_data   (head),
        .out_valid (vld[i]),
        .out_data  (data[i])
      );
    end else begin : g_next
      ssd_stage u_stage (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .in_valid  (vld[i-1]),
        .in_data   (data[i-1]),
        .out_valid (vld[i]),
        .out_data  (data[i])
      );
    end
  end

  assign result.valid          = vld[DATA_WIDTH-1];
  assign result.divide_by_zero = data[DATA_WIDTH-1].dbz;
  assign result.quotient       = data[DATA_WIDTH-1].dbz ? '0 : data[DATA_WIDTH-1].acc;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valid bits moved during stall");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    vld[DATA_WIDTH-1] && !data[DATA_WIDTH-1].dbz |->
      data[DATA_WIDTH-1].rem < data[DATA_WIDTH-1].div)
    else $error("final remainder not below divisor");

  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_by_zero |->
      result.quotient == '0 && data[DATA_WIDTH-1].div == '0)
    else $error("divide by zero flag inconsistent");

  a_head_dbz: assert property (@(posedge clk) disable iff (rst)
    vld[0] && $past(adv) |-> data[0].dbz == (data[0].div == '0))
    else $error("zero divisor flag lost at entry");

endmodule
`default_nettype wire

// ----- bench/shift_subtract_divider_tb.sv -----
`timescale 1ns / 100ps
module shift_subtract_divider_tb;
  import ssd_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_ITEMS = 550;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int SETTLE_CYCLES = 2 * DATA_WIDTH;
  localparam data_t DATA_MAX = '1;

  typedef struct packed {
    data_t quotient;
    logic  divide_by_zero;
  } quotient_rec_t;

  typedef struct packed {
    data_t dividend;
    data_t divisor;
    bit    typed;
    data_t quotient;
    bit    divide_by_zero;
  } directed_row_t;

  localparam int NUM_ROWS = 24;
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{31'd0, 31'd0, 1'b1, 31'd0, 1'b1},
    '{DATA_MAX, 31'd0, 1'b1, 31'd0, 1'b1},
    '{31'd12345, 31'd0, 1'b1, 31'd0, 1'b1},
    '{31'd0, 31'd1, 1'b1, 31'd0, 1'b0},
    '{31'd0, DATA_MAX, 1'b1, 31'd0, 1'b0},
    '{31'd1, 31'd1, 1'b1, 31'd1, 1'b0},
    '{DATA_MAX, 31'd1, 1'b1, DATA_MAX, 1'b0},
    '{DATA_MAX, DATA_MAX, 1'b1, 31'd1, 1'b0},
    '{DATA_MAX - 31'd1, DATA_MAX, 1'b1, 31'd0, 1'b0},
    '{31'd5, 31'd7, 1'b1, 31'd0, 1'b0},
    '{31'd1, DATA_MAX, 1'b1, 31'd0, 1'b0},
    '{DATA_MAX, 31'd2, 1'b1, 31'h3FFF_FFFF, 1'b0},
    '{31'd100, 31'd10, 1'b1, 31'd10, 1'b0},
    '{DATA_MAX, 31'h4000_0000, 1'b1, 31'd1, 1'b0},
    '{31'h4000_0000, 31'h4000_0000, 1'b1, 31'd1, 1'b0},
    '{31'h4000_0000, 31'd1, 1'b1, 31'h4000_0000, 1'b0},
    '{31'h5555_5555, 31'd3, 1'b0, 31'd0, 1'b0},
    '{31'h2AAA_AAAA, 31'h0000_5555, 1'b0, 31'd0, 1'b0},
    '{31'd1234567, 31'd89, 1'b0, 31'd0, 1'b0},
    '{DATA_MAX, 31'h0001_0001, 1'b0, 31'd0, 1'b0},
    '{31'h7FFF_0000, 31'h0000_FFFF, 1'b0, 31'd0, 1'b0},
    '{31'd6, 31'd4, 1'b0, 31'd0, 1'b0},
    '{31'd7, 31'd2, 1'b0, 31'd0, 1'b0},
    '{31'h3FFF_FFFF, 31'h3FFF_FFFE, 1'b0, 31'd0, 1'b0}
  };

  logic clk;
  logic rst;

  ssd_in_if  operands_if ();
  ssd_out_if result_if ();

  shift_subtract_divider uut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_if),
    .result   (result_if)
  );

  quotient_rec_t pending_quotients [$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  steady_phase = 1'b0;
  bit  hold_request = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic quotient_rec_t predict_quotient(input data_t num, input data_t den);
    logic [63:0] weight;
    logic [63:0] scaled;
    logic [63:0] remainder;
    logic [63:0] quo;
    quotient_rec_t rec;
    if (den == '0) begin
      rec.quotient = '0;
      rec.divide_by_zero = 1'b1;
      return rec;
    end
    weight = 64'd1;
    scaled = 64'(den);
    remainder = 64'(num);
    quo = '0;
    while (scaled < remainder) begin
      weight = weight << 1;
      scaled = scaled << 1;
    end
    while (weight != 0) begin
      if (scaled <= remainder) begin
        quo = quo + weight;
        remainder = remainder - scaled;
      end
      weight = weight >> 1;
      scaled = scaled >> 1;
    end
    rec.quotient = quo[DATA_WIDTH-1:0];
    rec.divide_by_zero = 1'b0;
    return rec;
  endfunction

  task automatic push_operands(input data_t num, input data_t den, input bit typed,
                               input quotient_rec_t typed_rec);
    operands_if.valid    <= 1'b1;
    operands_if.dividend <= num;
    operands_if.divisor  <= den;
    @(posedge clk);
    while (!operands_if.ready) @(posedge clk);
    pending_quotients.push_back(typed ? typed_rec : predict_quotient(num, den));
  endtask

  task automatic sender_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (!steady_phase) begin
      if (pick >= 92) gap = $urandom_range(10, 50);
      else if (pick >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      operands_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    operands_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_quotients.size() != 0) @(posedge clk);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else if (!steady_phase && $urandom_range(0, 99) < 25) begin
        result_if.ready <= 1'b0;
        stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                  : $urandom_range(10, 50);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    quotient_rec_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_quotients.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual quotient %h dbz %b",
                 $time, result_if.quotient, result_if.divide_by_zero);
        error_count++;
      end else begin
        want = pending_quotients.pop_front();
        if (result_if.quotient !== want.quotient) begin
          $display("%0t: quotient mismatch: expected %h, actual %h",
                   $time, want.quotient, result_if.quotient);
          error_count++;
        end
        if (result_if.divide_by_zero !== want.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                   $time, want.divide_by_zero, result_if.divide_by_zero);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    data_t num;
    data_t den;
    quotient_rec_t typed_rec;
    int width;
    rst = 1'b1;
    operands_if.valid = 1'b0;
    operands_if.dividend = '0;
    operands_if.divisor = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      typed_rec.quotient = DIRECTED_ROWS[i].quotient;
      typed_rec.divide_by_zero = DIRECTED_ROWS[i].divide_by_zero;
      push_operands(DIRECTED_ROWS[i].dividend, DIRECTED_ROWS[i].divisor,
                    DIRECTED_ROWS[i].typed, typed_rec);
      sender_gap();
    end
    drain_results();

    typed_rec = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) drain_results();
      // back-to-back items against a held-off receiver fill the pipeline
      if (i == 300) hold_request = 1'b1;
      steady_phase = (i >= 300 && i < 380) || (i % 100 >= 50 && i % 100 < 70);
      num = data_t'($urandom);
      den = data_t'($urandom);
      case ($urandom_range(0, 9))
        0: den = '0;
        1: num = data_t'($urandom_range(0, 1000));
        2, 3: den = data_t'($urandom_range(1, 16));
        4: begin
          width = $urandom_range(1, DATA_WIDTH);
          num = num >> (DATA_WIDTH - width);
          den = den >> $urandom_range(0, DATA_WIDTH - 1);
        end
        5: den = data_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
        6: den = num - data_t'($urandom_range(0, 3));
        default: ;
      endcase
      push_operands(num, den, 1'b0, typed_rec);
      sender_gap();
    end
    steady_phase = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ssd_pkg.sv
sv/ssd_in_if.sv
sv/ssd_out_if.sv
sv/ssd_stage.sv
sv/shift_subtract_divider.sv
bench/shift_subtract_divider_tb.sv
